// File: hw/rtl/kvbt_pkg.sv
`default_nettype none

package kvbt_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFESPAN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_VALUE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_BIAS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_R_SENSOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BOUND     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BOUND     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PUNISH        = 3'd7;

    // datapath micro-operations issued by the controller
    typedef enum logic [5:0] {
        CMD_NOP,
        CMD_R,
        CMD_M_DTR,
        CMD_EST,
        CMD_M_DTP11,
        CMD_T1,
        CMD_T2,
        CMD_T3,
        CMD_M_DTT,
        CMD_P0,
        CMD_M_QDT,
        CMD_P3,
        CMD_S,
        CMD_DIV0,
        CMD_DWAIT0,
        CMD_K0,
        CMD_DIV1,
        CMD_DWAIT1,
        CMD_K1,
        CMD_M_K0DV,
        CMD_EUPD,
        CMD_M_K1DV,
        CMD_BUPD,
        CMD_M_K0P0,
        CMD_W0,
        CMD_M_K0P1,
        CMD_W1,
        CMD_M_K1P0,
        CMD_W2,
        CMD_M_K1P1,
        CMD_W3,
        CMD_M_PUN,
        CMD_KP,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        logic load;
        logic out_load;
        t_cmd op;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic punish;
        logic div_done;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hw/rtl/kvbt_div.sv
`default_nettype none

module kvbt_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_num,
    input  logic signed [DATA_WIDTH-1:0] i_den,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_quo
);

    localparam int W  = DATA_WIDTH;
    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic                r_busy;
    logic                r_fin;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [NW-1:0]       r_acc;
    logic [W:0]          r_rem;
    logic [W-1:0]        r_den;
    logic                r_neg;
    logic                r_zero;
    logic signed [W-1:0] r_quo;

    logic [W:0]     rem2;
    logic [W+1:0]   diff;
    logic           ge;
    logic [W-1:0]   lim;
    logic [W-1:0]   qsel;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        return a[W-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
    endfunction

    // one restoring step per cycle
    assign rem2 = {r_rem[W-1:0], r_acc[NW-1]};
    assign diff = {1'b0, rem2} - {2'b00, r_den};
    assign ge   = !diff[W+1];

    // quotient saturation limit
    assign lim  = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, r_neg};
    assign qsel = (r_acc > NW'(lim)) ? lim : r_acc[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc  <= {mag(i_num), {FRAC_BITS{1'b0}}};
                r_rem  <= '0;
                r_den  <= mag(i_den);
                r_neg  <= i_num[W-1] ^ i_den[W-1];
                r_zero <= (i_den == '0);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[W:0] : rem2;
                r_acc <= {r_acc[NW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                if (r_zero) begin
                    r_quo <= '0;
                end else if (r_neg) begin
                    r_quo <= $signed(~qsel + 1'b1);
                end else begin
                    r_quo <= $signed(qsel);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/kvbt_ctrl.sv
`default_nettype none

module kvbt_ctrl
    import kvbt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RUN
    } t_state;

    t_state r_state;
    t_cmd   r_op;
    t_cmd   n_op;
    logic   r_out_valid;

    logic accept;
    logic slot_free;
    logic out_load;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign out_load  = (r_state == ST_RUN) && (r_op == CMD_OUT) && slot_free;

    // micro-op sequence
    always_comb begin
        case (r_op)
            CMD_R:       n_op = CMD_M_DTR;
            CMD_M_DTR:   n_op = CMD_EST;
            CMD_EST:     n_op = CMD_M_DTP11;
            CMD_M_DTP11: n_op = CMD_T1;
            CMD_T1:      n_op = CMD_T2;
            CMD_T2:      n_op = CMD_T3;
            CMD_T3:      n_op = CMD_M_DTT;
            CMD_M_DTT:   n_op = CMD_P0;
            CMD_P0:      n_op = CMD_M_QDT;
            CMD_M_QDT:   n_op = CMD_P3;
            CMD_P3:      n_op = CMD_S;
            CMD_S:       n_op = CMD_DIV0;
            CMD_DIV0:    n_op = CMD_DWAIT0;
            CMD_DWAIT0:  n_op = i_status.div_done ? CMD_K0 : CMD_DWAIT0;
            CMD_K0:      n_op = CMD_DIV1;
            CMD_DIV1:    n_op = CMD_DWAIT1;
            CMD_DWAIT1:  n_op = i_status.div_done ? CMD_K1 : CMD_DWAIT1;
            CMD_K1:      n_op = CMD_M_K0DV;
            CMD_M_K0DV:  n_op = CMD_EUPD;
            CMD_EUPD:    n_op = CMD_M_K1DV;
            CMD_M_K1DV:  n_op = CMD_BUPD;
            CMD_BUPD:    n_op = CMD_M_K0P0;
            CMD_M_K0P0:  n_op = CMD_W0;
            CMD_W0:      n_op = CMD_M_K0P1;
            CMD_M_K0P1:  n_op = CMD_W1;
            CMD_W1:      n_op = CMD_M_K1P0;
            CMD_M_K1P0:  n_op = CMD_W2;
            CMD_W2:      n_op = CMD_M_K1P1;
            CMD_M_K1P1:  n_op = CMD_W3;
            CMD_W3:      n_op = CMD_OUT;
            CMD_M_PUN:   n_op = CMD_KP;
            CMD_KP:      n_op = CMD_OUT;
            CMD_OUT:     n_op = CMD_OUT;
            default:     n_op = CMD_NOP;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= CMD_NOP;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    r_state <= ST_RUN;
                    if (i_status.punish) begin
                        r_op <= CMD_M_PUN;
                    end else if (i_status.skip) begin
                        r_op <= CMD_S;
                    end else begin
                        r_op <= CMD_R;
                    end
                end
                ST_RUN: begin
                    if (r_op == CMD_OUT) begin
                        if (slot_free) begin
                            r_out_valid <= 1'b1;
                            r_state     <= ST_IDLE;
                            r_op        <= CMD_NOP;
                        end
                    end else begin
                        r_op <= n_op;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.load     = accept;
    assign o_cmd.out_load = out_load;
    assign o_cmd.op       = r_op;

endmodule

`default_nettype wire

// File: hw/rtl/kvbt_datapath.sv
`default_nettype none

module kvbt_datapath
    import kvbt_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_operation,
    input  logic signed [31:0]   i_measured_value,
    input  logic signed [31:0]   i_rate_in,
    input  logic [31:0]          i_elapsed_time,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic signed [31:0]   o_estimate,
    output logic signed [31:0]   o_gain_score,
    output logic                 o_prediction_skipped
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int XW = DATA_WIDTH + 34;
    localparam logic signed [XW-1:0] SMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN_X = ~SMAX_X;

    function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] a);
        return XW'(a);
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [W-1:0] y;
        if (x > SMAX_X) begin
            y = SMAX_X[W-1:0];
        end else if (x < SMIN_X) begin
            y = SMIN_X[W-1:0];
        end else begin
            y = x[W-1:0];
        end
        return y;
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return sat(sx(a) + sx(b));
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return sat(sx(a) - sx(b));
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        return a[W-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
    endfunction

    // configuration registers
    logic signed [W-1:0] r_init, r_qv, r_qb, r_rs, r_pf;
    logic [31:0]         r_life;
    logic [15:0]         r_minb, r_maxb;

    // filter state
    logic signed [W-1:0] r_est, r_bias, r_p0, r_p1, r_p2, r_p3, r_k0, r_k1;

    // per-item operands and temporaries
    logic signed [W-1:0] r_meas, r_rate, r_dt;
    logic                r_skip, r_punish;
    logic signed [W-1:0] r_t, r_ta, r_s, r_dv, r_n0, r_n1;

    // shared multiplier
    logic signed [W-1:0] ma, mb;
    logic [2*W-1:0]      r_prod;
    logic                r_pneg;
    logic [2*W-1:0]      prod_sh;
    logic [W-1:0]        mlim;
    logic [W-1:0]        mmag;
    logic signed [W-1:0] mq;

    // output word
    logic [31:0] r_o_est, r_o_gain;
    logic        r_o_skip;

    logic signed [W-1:0]  lo_b, hi_b, est_sum, est_lo, est_clamped;
    logic signed [XW-1:0] est_x, gain_x;
    logic                 div_start, div_done;
    logic signed [W-1:0]  div_num, div_quo;
    logic signed [W-1:0]  cfg_init;

    // operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            CMD_M_DTR:   begin ma = r_dt;  mb = r_t;    end
            CMD_M_DTP11: begin ma = r_dt;  mb = r_p3;   end
            CMD_M_DTT:   begin ma = r_dt;  mb = r_t;    end
            CMD_M_QDT:   begin ma = r_qb;  mb = r_dt;   end
            CMD_M_K0DV:  begin ma = r_k0;  mb = r_dv;   end
            CMD_M_K1DV:  begin ma = r_k1;  mb = r_dv;   end
            CMD_M_K0P0:  begin ma = r_k0;  mb = r_p0;   end
            CMD_M_K0P1:  begin ma = r_k0;  mb = r_p1;   end
            CMD_M_K1P0:  begin ma = r_k1;  mb = r_p0;   end
            CMD_M_K1P1:  begin ma = r_k1;  mb = r_p1;   end
            CMD_M_PUN:   begin ma = r_k0;  mb = r_pf;   end
            default:     begin ma = '0;    mb = '0;     end
        endcase
    end

    // product magnitude registered, then scaled and saturated
    always_ff @(posedge i_clk) begin
        r_prod <= (2*W)'(mag(ma)) * (2*W)'(mag(mb));
        r_pneg <= ma[W-1] ^ mb[W-1];
    end

    assign prod_sh = r_prod >> F;
    assign mlim    = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, r_pneg};
    assign mmag    = (prod_sh > (2*W)'(mlim)) ? mlim : prod_sh[W-1:0];
    assign mq      = r_pneg ? $signed(~mmag + 1'b1) : $signed(mmag);

    // clamp bounds and predicted estimate
    assign lo_b = sat($signed({{(XW-16-F){1'b0}}, r_minb, {F{1'b0}}}));
    assign hi_b = sat($signed({{(XW-16-F){1'b0}}, r_maxb, {F{1'b0}}}));
    assign est_sum     = sadd(r_est, mq);
    assign est_lo      = (est_sum < lo_b) ? lo_b : est_sum;
    assign est_clamped = (est_lo > hi_b) ? hi_b : est_lo;

    // divider hookup
    assign div_start = (i_cmd.op == CMD_DIV0) || (i_cmd.op == CMD_DIV1);
    assign div_num   = (i_cmd.op == CMD_DIV1) ? r_p2 : r_p0;

    kvbt_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign cfg_init = sat(XW'($signed(i_cfg_data)));
    assign est_x    = sx(r_est);
    assign gain_x   = sx(r_k0);

    // state, configuration and micro-op execution
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= '0;
            r_life   <= 32'd65536;
            r_qv     <= sat(XW'(66));
            r_qb     <= sat(XW'(197));
            r_rs     <= sat(XW'(1966));
            r_minb   <= 16'd0;
            r_maxb   <= 16'hFFFF;
            r_pf     <= sat(XW'(32768));
            r_est    <= '0;
            r_bias   <= '0;
            r_p0     <= '0;
            r_p1     <= '0;
            r_p2     <= '0;
            r_p3     <= '0;
            r_k0     <= '0;
            r_k1     <= '0;
            r_skip   <= 1'b0;
            r_punish <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INITIAL_VALUE: r_init <= cfg_init;
                CFG_LIFESPAN:      r_life <= i_cfg_data;
                CFG_Q_VALUE:       r_qv   <= sat($signed(XW'(i_cfg_data[30:0])));
                CFG_Q_BIAS:        r_qb   <= sat($signed(XW'(i_cfg_data[30:0])));
                CFG_R_SENSOR:      r_rs   <= sat($signed(XW'(i_cfg_data[30:0])));
                CFG_MIN_BOUND:     r_minb <= i_cfg_data[15:0];
                CFG_MAX_BOUND:     r_maxb <= i_cfg_data[15:0];
                CFG_PUNISH:        r_pf   <= sat($signed(XW'(i_cfg_data[16:0])));
            endcase
            // any write restarts the filter
            r_est  <= (i_cfg_index == CFG_INITIAL_VALUE) ? cfg_init : r_init;
            r_bias <= '0;
            r_p0   <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
            r_p3   <= '0;
            r_k0   <= '0;
            r_k1   <= '0;
        end else begin
            // capture the input word
            if (i_cmd.load) begin
                r_meas   <= sat(XW'(i_measured_value));
                r_rate   <= sat(XW'(i_rate_in));
                r_dt     <= sat($signed(XW'(i_elapsed_time)));
                r_skip   <= !i_operation && (i_elapsed_time > r_life);
                r_punish <= i_operation;
            end
            case (i_cmd.op)
                CMD_R:   r_t   <= ssub(r_rate, r_bias);
                CMD_EST: r_est <= est_clamped;
                CMD_T1: begin
                    r_ta <= mq;
                    r_t  <= ssub(mq, r_p1);
                end
                CMD_T2:  r_t <= ssub(r_t, r_p2);
                CMD_T3:  r_t <= sadd(r_t, r_qv);
                CMD_P0: begin
                    r_p0 <= sadd(r_p0, mq);
                    r_p1 <= ssub(r_p1, r_ta);
                    r_p2 <= ssub(r_p2, r_ta);
                end
                CMD_P3:  r_p3 <= sadd(r_p3, mq);
                CMD_S: begin
                    r_s  <= sadd(r_p0, r_rs);
                    r_dv <= ssub(r_meas, r_est);
                end
                CMD_K0:   r_k0   <= div_quo;
                CMD_K1:   r_k1   <= div_quo;
                CMD_EUPD: r_est  <= sadd(r_est, mq);
                CMD_BUPD: r_bias <= sadd(r_bias, mq);
                CMD_W0:   r_n0   <= ssub(r_p0, mq);
                CMD_W1:   r_n1   <= ssub(r_p1, mq);
                CMD_W2:   r_p2   <= ssub(r_p2, mq);
                CMD_W3: begin
                    r_p3 <= ssub(r_p3, mq);
                    r_p0 <= r_n0;
                    r_p1 <= r_n1;
                end
                CMD_KP:  r_k0 <= mq;
                default: r_t  <= r_t;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_est  <= est_x[31:0];
            r_o_gain <= gain_x[31:0];
            r_o_skip <= r_skip;
        end
    end

    assign o_status.skip        = r_skip;
    assign o_status.punish      = r_punish;
    assign o_status.div_done    = div_done;
    assign o_estimate           = $signed(r_o_est);
    assign o_gain_score         = $signed(r_o_gain);
    assign o_prediction_skipped = r_o_skip;

endmodule

`default_nettype wire

// File: hw/rtl/kalman_value_bias_tracker.sv
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   operation, measured_value, rate_in,
//                                                elapsed_time
// output    out        o_out_valid / i_out_stall estimate, gain_score, prediction_skipped
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// a step word runs the bit-serial divider twice between accept and result valid;
// skipping leaves out the prediction micro-ops ahead of the divides
// a punish word goes from accept to result valid through the shared multiplier alone
// one word is in work at a time; the next word can be taken in the cycle after the result loads
// synchronous active-low reset restores the register defaults and clears the filter state
// a stalled output holds; the next word is taken while the previous result waits
`default_nettype none

module kalman_value_bias_tracker
    import kvbt_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic signed [31:0]   i_measured_value,
    input  logic signed [31:0]   i_rate_in,
    input  logic [31:0]          i_elapsed_time,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_estimate,
    output logic signed [31:0]   o_gain_score,
    output logic                 o_prediction_skipped
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    kvbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // arithmetic and state
    kvbt_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_operation          (i_operation),
        .i_measured_value     (i_measured_value),
        .i_rate_in            (i_rate_in),
        .i_elapsed_time       (i_elapsed_time),
        .i_cmd                (cmd),
        .o_status             (status),
        .o_estimate           (o_estimate),
        .o_gain_score         (o_gain_score),
        .o_prediction_skipped (o_prediction_skipped)
    );

endmodule

`default_nettype wire

// File: hw/rtl/kvbt_checker.sv
`default_nettype none

module kvbt_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic signed [31:0]   o_estimate,
    input  logic signed [31:0]   o_gain_score,
    input  logic                 o_prediction_skipped
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_estimate)
            && $stable(o_gain_score) && $stable(o_prediction_skipped)))
        else $error("stalled result changed");

    // an accepted word keeps the block busy the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a new result only comes out of a word in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a word in work");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind kalman_value_bias_tracker kvbt_checker u_chk (.*);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import kvbt_pkg::*;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam bit OP_STEP = 1'b0;
    localparam bit OP_PUNISH = 1'b1;

    typedef struct {
        bit             op;
        logic [31:0]    meas;
        logic [31:0]    rate;
        logic [31:0]    et;
        bit             check_fixed;
        logic [31:0]    x_est;
        logic [31:0]    x_gain;
        bit             x_skip;
    } t_row;

    typedef struct {
        logic [31:0] est;
        logic [31:0] gain;
        bit          skip;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_operation = 1'b0;
    logic signed [31:0] i_measured_value = '0;
    logic signed [31:0] i_rate_in = '0;
    logic [31:0] i_elapsed_time = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_estimate;
    logic signed [31:0] o_gain_score;
    logic o_prediction_skipped;

    kalman_value_bias_tracker u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_measured_value(i_measured_value),
        .i_rate_in(i_rate_in), .i_elapsed_time(i_elapsed_time),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_estimate(o_estimate), .o_gain_score(o_gain_score),
        .o_prediction_skipped(o_prediction_skipped)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // filter model state
    longint cfg_init, cfg_qv, cfg_qb, cfg_r, cfg_pun;
    longint unsigned cfg_life, cfg_min, cfg_max;
    longint flt_est, flt_bias, flt_k0, flt_k1;
    longint flt_p[4];

    t_res expected_q[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    function automatic longint sat(longint x);
        if (x > SMAX) return SMAX;
        if (x < SMIN) return SMIN;
        return x;
    endfunction

    function automatic longint sadd(longint a, longint b);
        return sat(a + b);
    endfunction

    function automatic longint ssub(longint a, longint b);
        return sat(a - b);
    endfunction

    // exact product with magnitude truncation, operands fit in 32 bits
    function automatic longint qmul(longint a, longint b);
        bit neg;
        longint unsigned m;
        neg = (a < 0) != (b < 0);
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> 16;
        if (neg) return (m > 64'd2147483648) ? SMIN : -longint'(m);
        return (m > 64'd2147483647) ? SMAX : longint'(m);
    endfunction

    function automatic longint qdiv(longint n, longint d);
        bit neg;
        logic [127:0] num, q;
        longint unsigned m;
        if (d == 0) return 0;
        neg = (n < 0) != (d < 0);
        num = 128'(n < 0 ? -n : n) << 16;
        q = num / 128'(d < 0 ? -d : d);
        m = (q > 128'd4294967296) ? 64'd4294967296 : q[63:0];
        if (neg) return (m > 64'd2147483648) ? SMIN : -longint'(m);
        return (m > 64'd2147483647) ? SMAX : longint'(m);
    endfunction

    function automatic void filter_reload();
        flt_est = cfg_init;
        flt_bias = 0;
        flt_k0 = 0;
        flt_k1 = 0;
        foreach (flt_p[i]) flt_p[i] = 0;
    endfunction

    function automatic void filter_defaults();
        cfg_init = 0; cfg_life = 65536; cfg_qv = 66; cfg_qb = 197;
        cfg_r = 1966; cfg_min = 0; cfg_max = 65535; cfg_pun = 32768;
        filter_reload();
    endfunction

    function automatic void filter_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        case (idx)
            CFG_INITIAL_VALUE: cfg_init = longint'($signed(v));
            CFG_LIFESPAN:      cfg_life = v;
            CFG_Q_VALUE:       cfg_qv = v[30:0];
            CFG_Q_BIAS:        cfg_qb = v[30:0];
            CFG_R_SENSOR:      cfg_r = v[30:0];
            CFG_MIN_BOUND:     cfg_min = v[15:0];
            CFG_MAX_BOUND:     cfg_max = v[15:0];
            CFG_PUNISH:        cfg_pun = 32'(v[16:0]);
            default: ;
        endcase
        filter_reload();
    endfunction

    function automatic t_res filter_predict(bit op, logic [31:0] meas_w,
                                            logic [31:0] rate_w, logic [31:0] et_w);
        t_res res;
        longint meas, rate, dt, lo, hi, dtp11, t, s, dv, p00o, p01o;
        res.skip = 1'b0;
        if (op == OP_PUNISH) begin
            flt_k0 = qmul(flt_k0, cfg_pun);
        end else begin
            meas = longint'($signed(meas_w));
            rate = longint'($signed(rate_w));
            if (longint'(et_w) > longint'(cfg_life)) begin
                res.skip = 1'b1;
            end else begin
                dt = sat(longint'(et_w));
                lo = sat(cfg_min << 16);
                hi = sat(cfg_max << 16);
                flt_est = sadd(flt_est, qmul(dt, ssub(rate, flt_bias)));
                if (flt_est < lo) flt_est = lo;
                if (flt_est > hi) flt_est = hi;
                dtp11 = qmul(dt, flt_p[3]);
                t = sadd(ssub(ssub(dtp11, flt_p[1]), flt_p[2]), cfg_qv);
                flt_p[0] = sadd(flt_p[0], qmul(dt, t));
                flt_p[1] = ssub(flt_p[1], dtp11);
                flt_p[2] = ssub(flt_p[2], dtp11);
                flt_p[3] = sadd(flt_p[3], qmul(cfg_qb, dt));
            end
            s = sadd(flt_p[0], cfg_r);
            flt_k0 = qdiv(flt_p[0], s);
            flt_k1 = qdiv(flt_p[2], s);
            dv = ssub(meas, flt_est);
            flt_est = sadd(flt_est, qmul(flt_k0, dv));
            flt_bias = sadd(flt_bias, qmul(flt_k1, dv));
            p00o = flt_p[0];
            p01o = flt_p[1];
            flt_p[0] = ssub(flt_p[0], qmul(flt_k0, p00o));
            flt_p[1] = ssub(flt_p[1], qmul(flt_k0, p01o));
            flt_p[2] = ssub(flt_p[2], qmul(flt_k1, p00o));
            flt_p[3] = ssub(flt_p[3], qmul(flt_k1, p01o));
        end
        res.est = flt_est[31:0];
        res.gain = flt_k0[31:0];
        return res;
    endfunction

    // receiver: stall and compare
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word est=%h gain=%h skip=%b", $realtime,
                         o_estimate, o_gain_score, o_prediction_skipped);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_estimate !== exp_r.est) begin
                    $display("%0t: estimate expected %h actual %h", $realtime,
                             exp_r.est, o_estimate);
                    errors++;
                end
                if (o_gain_score !== exp_r.gain) begin
                    $display("%0t: gain_score expected %h actual %h", $realtime,
                             exp_r.gain, o_gain_score);
                    errors++;
                end
                if (o_prediction_skipped !== exp_r.skip) begin
                    $display("%0t: prediction_skipped expected %b actual %b", $realtime,
                             exp_r.skip, o_prediction_skipped);
                    errors++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        filter_config(idx, v);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // send one word; fixed expectation overrides the predictor when given
    task automatic send_word(t_row r);
        t_res pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= r.op;
        i_measured_value <= r.meas;
        i_rate_in <= r.rate;
        i_elapsed_time <= r.et;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = filter_predict(r.op, r.meas, r.rate, r.et);
        if (r.check_fixed) begin
            pred.est = r.x_est;
            pred.gain = r.x_gain;
            pred.skip = r.x_skip;
        end
        expected_q.push_back(pred);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(65535) << 16;
            3: return $urandom_range(262143) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_dt();
        case ($urandom_range(4))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return $urandom;
            default: return $urandom_range(98304);
        endcase
    endfunction

    task automatic random_cfg(int phase);
        logic [31:0] mn, mx;
        mn = (phase % 3 == 0) ? 32'd0 : $urandom_range(2000);
        mx = (phase % 3 == 1) ? 32'd65535 : mn + $urandom_range(3000);
        if (phase == 5) begin
            mn = 32'hffff;
            mx = 32'h0;
        end
        write_reg(CFG_LIFESPAN, (phase == 4) ? 32'hffff_ffff : $urandom_range(196608));
        write_reg(CFG_Q_VALUE, (phase == 2) ? 32'hffff_ffff : $urandom_range(5000));
        write_reg(CFG_Q_BIAS, (phase == 3) ? 32'h7fff_ffff : $urandom_range(5000));
        write_reg(CFG_R_SENSOR, (phase == 1) ? 32'h0 :
                  (phase == 6) ? 32'h7fff_ffff : 1 + $urandom_range(200000));
        write_reg(CFG_MIN_BOUND, mn);
        write_reg(CFG_MAX_BOUND, mx);
        write_reg(CFG_PUNISH, (phase == 7) ? 32'h1ffff : $urandom_range(65536));
        write_reg(CFG_INITIAL_VALUE, (phase == 2) ? 32'h8000_0000 :
                  (phase == 3) ? 32'h7fff_ffff : (mn + $urandom_range(100)) << 16);
        i_cfg_we <= 1'b0;
    endtask

    t_row dir_rows[$];

    initial begin
        t_row r;
        filter_defaults();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: fixed values are readable from reset state
        dir_rows = '{
            '{OP_PUNISH, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 1'b0},
            '{OP_STEP, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 1, 32'h0, 32'h0, 1'b1},
            '{OP_STEP, 32'h8000_0000, 32'h8000_0000, 32'h0, 0, 0, 0, 0},
            '{OP_STEP, 32'h0001_0000, 32'h7fff_ffff, 32'h0001_0000, 0, 0, 0, 0},
            '{OP_STEP, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 0, 0, 0, 0},
            '{OP_STEP, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_8000, 0, 0, 0, 0},
            '{OP_PUNISH, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0},
            '{OP_STEP, 32'h0010_0000, 32'h0, 32'h0001_0001, 0, 0, 0, 0},
            '{OP_STEP, 32'hffff_ffff, 32'hffff_ffff, 32'h0001_0000, 0, 0, 0, 0},
            '{OP_PUNISH, 32'h0, 32'h0, 32'h0, 0, 0, 0, 0},
            '{OP_STEP, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 0, 0, 0, 0},
            '{OP_STEP, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_ffff, 0, 0, 0, 0}
        };
        foreach (dir_rows[i]) send_word(dir_rows[i]);
        drain();

        // random phases with config changes and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            random_cfg(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < 100; n++) begin
                r.op = ($urandom_range(9) == 0) ? OP_PUNISH : OP_STEP;
                r.meas = rand_q();
                r.rate = ($urandom_range(3) == 0) ? rand_q() : $urandom_range(131072) - 65536;
                r.et = rand_dt();
                r.check_fixed = 0;
                send_word(r);
                if (n == 50) drain();
            end
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
